FILE: rtl/ubs_pkg.sv
// Shared types, constants and the byte classifier for the UTF-8 byte sanitizer.
// Used by ubs_front, ubs_engine, ubs_out_queue and the top level.
// No dependencies.
`timescale 1ns / 1ps

package ubs_pkg;

   localparam int IN_DEPTH  = 2;
   localparam int IN_PTR_W  = $clog2(IN_DEPTH);
   localparam int IN_CNT_W  = $clog2(IN_DEPTH + 1);
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

   localparam logic [7:0] ASCII_LIMIT = 8'h80;
   localparam logic [7:0] CONT_LIMIT  = 8'hC0;
   localparam logic [7:0] MASK_LEAD2  = 8'hE0;
   localparam logic [7:0] MASK_LEAD3  = 8'hF0;
   localparam logic [7:0] MASK_LEAD4  = 8'hF8;
   localparam logic [7:0] CODE_LEAD2  = 8'hC0;
   localparam logic [7:0] CODE_LEAD3  = 8'hE0;
   localparam logic [7:0] CODE_LEAD4  = 8'hF0;
   localparam logic [7:0] REPL_BYTE0  = 8'hEF;
   localparam logic [7:0] REPL_BYTE1  = 8'hBF;
   localparam logic [7:0] REPL_BYTE2  = 8'hBD;

   typedef enum logic [2:0] {
      CLS_ASCII,
      CLS_LEAD2,
      CLS_LEAD3,
      CLS_LEAD4,
      CLS_BAD
   } byte_class_type;

   typedef struct packed {
      logic [7:0]     data;
      logic           last;
      byte_class_type cls;
   } in_item_type;

   typedef struct packed {
      logic [7:0]     data;
      byte_class_type cls;
   } win_entry_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       string_end;
   } rsp_item_type;

   function automatic byte_class_type classify(input logic [7:0] b);
      byte_class_type c;
      priority if (b < ASCII_LIMIT)             c = CLS_ASCII;
      else if ((b & MASK_LEAD2) == CODE_LEAD2)  c = CLS_LEAD2;
      else if ((b & MASK_LEAD3) == CODE_LEAD3)  c = CLS_LEAD3;
      else if ((b & MASK_LEAD4) == CODE_LEAD4)  c = CLS_LEAD4;
      else                                      c = CLS_BAD;
      return c;
   endfunction

   // continuation bytes a lead needs
   function automatic logic [1:0] followers(input byte_class_type c);
      logic [1:0] n;
      unique case (c)
         CLS_LEAD2: n = 2'd1;
         CLS_LEAD3: n = 2'd2;
         CLS_LEAD4: n = 2'd3;
         default:   n = 2'd0;
      endcase
      return n;
   endfunction

endpackage

FILE: rtl/ubs_front.sv
// Front end: accepts request bytes, classifies them and queues them for the engine.
// Depends on ubs_pkg.
`timescale 1ns / 1ps

module ubs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_string_last,
   output logic                 item_valid,
   output ubs_pkg::in_item_type item,
   input  logic                 item_take
);

   ubs_pkg::in_item_type                 mem_ff [ubs_pkg::IN_DEPTH];
   ubs_pkg::in_item_type                 wr_item;
   logic [ubs_pkg::IN_PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [ubs_pkg::IN_PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [ubs_pkg::IN_CNT_W-1:0]         count_ff, count_in;
   logic                                 do_push, do_pop;

   assign full       = (count_ff == ubs_pkg::IN_CNT_W'(ubs_pkg::IN_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = item_take && item_valid;

   always_comb begin
      wr_item.data = req_data_byte;
      wr_item.last = req_string_last;
      wr_item.cls  = ubs_pkg::classify(req_data_byte);
      wr_ptr_in    = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/ubs_engine.sv
// Back end: byte window, sequence decisions, one byte out per cycle unless out_full.
// The last emitted byte waits in a hold register until the request's run end is known.
// Depends on ubs_pkg.
`timescale 1ns / 1ps

module ubs_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  ubs_pkg::in_item_type  item,
   output logic                  item_take,
   input  logic                  out_full,
   output logic                  out_push,
   output ubs_pkg::rsp_item_type out_item
);

   typedef enum logic [1:0] {
      REP_NONE,
      REP_BYTE1,
      REP_BYTE2
   } rep_phase_type;

   ubs_pkg::win_entry_type win_ff [4];
   ubs_pkg::win_entry_type win_in [4];
   ubs_pkg::win_entry_type pend_ff [3];
   ubs_pkg::win_entry_type pend_in [3];
   logic [1:0]    pcount_ff, pcount_in;
   logic [2:0]    n_ff, n_in;
   logic          last_ff, last_in;
   logic          busy_ff, busy_in;
   rep_phase_type rep_ff, rep_in;
   logic [1:0]    copy_ff, copy_in;
   logic [7:0]    hold_ff, hold_in;
   logic          hold_valid_ff, hold_valid_in;

   logic       emit_en, finish_en, shift_en, save_en, fail;
   logic [7:0] emit_byte;
   logic [1:0] need;
   logic [2:0] avail;

   always_comb begin
      need  = ubs_pkg::followers(win_ff[0].cls);
      avail = n_ff - 3'd1;
      fail  = 1'b0;
      for (int j = 1; j < 4; j++) begin
         if ((3'(j) <= avail) && (3'(j) <= {1'b0, need})) begin
            if (need == 2'd1) begin
               if (win_ff[j].data < ubs_pkg::ASCII_LIMIT ||
                   win_ff[j].data >= ubs_pkg::CONT_LIMIT) begin
                  fail = 1'b1;
               end
            end else if (win_ff[j].data < ubs_pkg::ASCII_LIMIT) begin
               fail = 1'b1;
            end
         end
      end
   end

   always_comb begin
      win_in        = win_ff;
      pend_in       = pend_ff;
      pcount_in     = pcount_ff;
      n_in          = n_ff;
      last_in       = last_ff;
      busy_in       = busy_ff;
      rep_in        = rep_ff;
      copy_in       = copy_ff;
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      item_take     = 1'b0;
      out_push      = 1'b0;
      out_item      = '0;
      emit_en       = 1'b0;
      emit_byte     = win_ff[0].data;
      finish_en     = 1'b0;
      shift_en      = 1'b0;
      save_en       = 1'b0;

      if (!busy_ff) begin
         if (item_valid) begin
            // window = held bytes followed by the new byte
            item_take = 1'b1;
            for (int i = 0; i < 4; i++) begin
               if (3'(i) < {1'b0, pcount_ff}) begin
                  win_in[i] = pend_ff[i < 3 ? i : 2];
               end else begin
                  win_in[i].data = item.data;
                  win_in[i].cls  = item.cls;
               end
            end
            n_in      = {1'b0, pcount_ff} + 3'd1;
            last_in   = item.last;
            busy_in   = 1'b1;
            rep_in    = REP_NONE;
            copy_in   = '0;
            pcount_in = '0;
         end
      end else if (!out_full) begin
         priority if (rep_ff == REP_BYTE1) begin
            emit_en   = 1'b1;
            emit_byte = ubs_pkg::REPL_BYTE1;
            rep_in    = REP_BYTE2;
         end else if (rep_ff == REP_BYTE2) begin
            emit_en   = 1'b1;
            emit_byte = ubs_pkg::REPL_BYTE2;
            rep_in    = REP_NONE;
            shift_en  = 1'b1;
         end else if (copy_ff != '0) begin
            // followers of an accepted sequence go out raw
            emit_en  = 1'b1;
            shift_en = 1'b1;
            copy_in  = copy_ff - 2'd1;
         end else if (n_ff == '0) begin
            finish_en = 1'b1;
         end else begin
            unique case (win_ff[0].cls)
               ubs_pkg::CLS_ASCII: begin
                  emit_en  = 1'b1;
                  shift_en = 1'b1;
               end
               ubs_pkg::CLS_BAD: begin
                  emit_en   = 1'b1;
                  emit_byte = ubs_pkg::REPL_BYTE0;
                  rep_in    = REP_BYTE1;
               end
               default: begin
                  if (fail) begin
                     emit_en   = 1'b1;
                     emit_byte = ubs_pkg::REPL_BYTE0;
                     rep_in    = REP_BYTE1;
                  end else if (avail >= {1'b0, need}) begin
                     emit_en  = 1'b1;
                     shift_en = 1'b1;
                     copy_in  = need;
                  end else if (last_ff) begin
                     emit_en   = 1'b1;
                     emit_byte = ubs_pkg::REPL_BYTE0;
                     rep_in    = REP_BYTE1;
                  end else begin
                     // incomplete sequence: keep it for the next request
                     save_en   = 1'b1;
                     finish_en = 1'b1;
                  end
               end
            endcase
         end
      end

      if (shift_en) begin
         for (int i = 0; i < 3; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         n_in = n_ff - 3'd1;
      end

      if (save_en) begin
         for (int i = 0; i < 3; i++) begin
            pend_in[i] = win_ff[i];
         end
         pcount_in = n_ff[1:0];
      end

      if (emit_en) begin
         if (hold_valid_ff) begin
            out_push          = 1'b1;
            out_item.out_byte = hold_ff;
         end
         hold_in       = emit_byte;
         hold_valid_in = 1'b1;
      end

      if (finish_en) begin
         if (hold_valid_ff) begin
            out_push            = 1'b1;
            out_item.out_byte   = hold_ff;
            out_item.run_end    = 1'b1;
            out_item.string_end = last_ff;
         end
         hold_valid_in = 1'b0;
         busy_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      pend_ff <= pend_in;
      last_ff <= last_in;
      hold_ff <= hold_in;
      if (reset) begin
         pcount_ff     <= '0;
         n_ff          <= '0;
         busy_ff       <= 1'b0;
         rep_ff        <= REP_NONE;
         copy_ff       <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         pcount_ff     <= pcount_in;
         n_ff          <= n_in;
         busy_ff       <= busy_in;
         rep_ff        <= rep_in;
         copy_ff       <= copy_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

endmodule

FILE: rtl/ubs_out_queue.sv
// Result queue between the engine and the rsp_ ports.
// Depends on ubs_pkg.
`timescale 1ns / 1ps

module ubs_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_push,
   input  ubs_pkg::rsp_item_type in_item,
   output logic                  in_full,
   input  logic                  pop,
   output logic                  empty,
   output ubs_pkg::rsp_item_type head
);

   ubs_pkg::rsp_item_type         mem_ff [ubs_pkg::OUT_DEPTH];
   logic [ubs_pkg::OUT_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ubs_pkg::OUT_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ubs_pkg::OUT_CNT_W-1:0] count_ff, count_in;
   logic                          do_push, do_pop;

   assign in_full = (count_ff == ubs_pkg::OUT_CNT_W'(ubs_pkg::OUT_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = in_push && !in_full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/utf8_byte_sanitizer_top.sv
// Top level of the UTF-8 byte sanitizer: front queue, sequence engine, result queue.
// Depends on ubs_pkg, ubs_front, ubs_engine, ubs_out_queue.
//
//   channel   direction  handshake     payload
//   request   in         push / full   req_data_byte, req_string_last
//   response  out        pop / empty   rsp_out_byte, rsp_run_end, rsp_string_end
//
// The engine takes one request byte when idle, then emits one byte per cycle
// while out_full is low (three per replacement), then closes the request.
// A new request is taken only after closing; the engine loop sets the pace.
// Reset is synchronous and clears the queues and any held partial sequence.
// Either side may stall freely: both queues decouple it from the engine.
`timescale 1ns / 1ps

module utf8_byte_sanitizer_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_data_byte,
   input  logic       req_string_last,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end,
   output logic       rsp_string_end
);

   logic                  item_valid, item_take, out_full, out_push;
   ubs_pkg::in_item_type  item;
   ubs_pkg::rsp_item_type out_item, head;

   ubs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_data_byte   (req_data_byte),
      .req_string_last (req_string_last),
      .item_valid      (item_valid),
      .item            (item),
      .item_take       (item_take)
   );

   ubs_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_item   (out_item)
   );

   ubs_out_queue u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .in_push (out_push),
      .in_item (out_item),
      .in_full (out_full),
      .pop     (pop),
      .empty   (empty),
      .head    (head)
   );

   assign rsp_out_byte   = head.out_byte;
   assign rsp_run_end    = head.run_end;
   assign rsp_string_end = head.string_end;

endmodule
